// ===== rtl/core/ibl_pkg.sv =====
// Shared types and constants of the interval bucket lookup unit.
`timescale 1ns / 1ps
`default_nettype none

package ibl_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 1024;

   localparam int unsigned START_W      = 32;
   localparam int unsigned FEATURE_W    = 64;
   localparam int unsigned SLOT_FIELD_W = 10;
   localparam int unsigned COUNT_W      = 11;

   localparam int unsigned REQ_DATA_W = 144;
   localparam int unsigned RSP_DATA_W = 80;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [FEATURE_W-1:0] NULL_FEATURE = {1'b1, {(FEATURE_W - 1){1'b0}}};

   typedef struct packed {
      logic                        lookup;
      logic                        wr_en;
      logic [SLOT_FIELD_W-1:0]     wr_slot;
      logic [START_W-1:0]          wr_start;
      logic signed [FEATURE_W-1:0] wr_feature;
      logic [START_W-1:0]          value;
   } req_type;

   typedef struct packed {
      logic active;
      logic found;
   } flags_type;

endpackage

`default_nettype wire

// ===== rtl/core/ibl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ibl_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ibl_entry.sv =====
// Entry stage: count clamp and bounds check against the first and last used start.
`timescale 1ns / 1ps
`default_nettype none

module ibl_entry import ibl_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  req_type                        in_req,
   input  logic [COUNT_W-1:0]             entry_count,
   output logic                           out_valid,
   output req_type                        out_req,
   output flags_type                      out_flags,
   output logic [$clog2(TABLE_DEPTH)-1:0] out_lo,
   output logic [$clog2(TABLE_DEPTH)-1:0] out_hi
);

   localparam int unsigned SLOT_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W  = (COUNT_W > SLOT_W + 1) ? COUNT_W : SLOT_W + 1;

   logic [CNT_W-1:0]   count_wide;
   logic [CNT_W-1:0]   count_sat;
   logic [SLOT_W-1:0]  last_slot;
   logic [SLOT_W-1:0]  wr_addr;
   logic               wr_fire;
   logic [START_W-1:0] first_start;
   logic [START_W-1:0] last_start;

   logic               s1_valid_ff;
   req_type            s1_req_ff;
   logic               s1_empty_ff;
   logic [SLOT_W-1:0]  s1_hi_ff;

   flags_type          flags_in;
   logic [SLOT_W-1:0]  lo_in;

   logic               out_valid_ff;
   req_type            out_req_ff;
   flags_type          out_flags_ff;
   logic [SLOT_W-1:0]  out_lo_ff;
   logic [SLOT_W-1:0]  out_hi_ff;

   assign count_wide = CNT_W'(entry_count);
   assign count_sat  = (count_wide > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_wide;
   assign last_slot  = SLOT_W'(count_sat - CNT_W'(1));
   assign wr_addr    = SLOT_W'(in_req.wr_slot);
   assign wr_fire    = advance && in_valid && in_req.wr_en;

   ibl_ram #(
      .WIDTH (START_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram_first (
      .clock   (clock),
      .wr_en   (wr_fire),
      .wr_addr (wr_addr),
      .wr_data (in_req.wr_start),
      .rd_en   (advance),
      .rd_addr ('0),
      .rd_data (first_start)
   );

   ibl_ram #(
      .WIDTH (START_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram_last (
      .clock   (clock),
      .wr_en   (wr_fire),
      .wr_addr (wr_addr),
      .wr_data (in_req.wr_start),
      .rd_en   (advance),
      .rd_addr (last_slot),
      .rd_data (last_start)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_req_ff   <= in_req;
         s1_empty_ff <= (count_sat == '0);
         s1_hi_ff    <= last_slot;
      end
   end

   always_comb begin
      flags_in = '0;
      lo_in    = '0;
      if (s1_req_ff.lookup && !s1_empty_ff && (s1_req_ff.value >= first_start)) begin
         flags_in.found = 1'b1;
         if (s1_req_ff.value >= last_start) begin
            lo_in = s1_hi_ff;
         end else begin
            flags_in.active = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_req_ff   <= s1_req_ff;
         out_flags_ff <= flags_in;
         out_lo_ff    <= lo_in;
         out_hi_ff    <= s1_hi_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_req   = out_req_ff;
   assign out_flags = out_flags_ff;
   assign out_lo    = out_lo_ff;
   assign out_hi    = out_hi_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ibl_step.sv =====
// One bisection step: probe start[mid] and start[mid+1], each from a private table copy.
`timescale 1ns / 1ps
`default_nettype none

module ibl_step import ibl_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  req_type                        in_req,
   input  flags_type                      in_flags,
   input  logic [$clog2(TABLE_DEPTH)-1:0] in_lo,
   input  logic [$clog2(TABLE_DEPTH)-1:0] in_hi,
   output logic                           out_valid,
   output req_type                        out_req,
   output flags_type                      out_flags,
   output logic [$clog2(TABLE_DEPTH)-1:0] out_lo,
   output logic [$clog2(TABLE_DEPTH)-1:0] out_hi
);

   localparam int unsigned SLOT_W = $clog2(TABLE_DEPTH);

   logic [SLOT_W:0]    span_sum;
   logic [SLOT_W-1:0]  mid;
   logic [SLOT_W-1:0]  mid_next;
   logic [SLOT_W-1:0]  wr_addr;
   logic               wr_fire;
   logic [START_W-1:0] mid_start;
   logic [START_W-1:0] next_start;

   logic               s1_valid_ff;
   req_type            s1_req_ff;
   flags_type          s1_flags_ff;
   logic [SLOT_W-1:0]  s1_lo_ff;
   logic [SLOT_W-1:0]  s1_hi_ff;
   logic [SLOT_W-1:0]  s1_mid_ff;

   flags_type          flags_in;
   logic [SLOT_W-1:0]  lo_in;
   logic [SLOT_W-1:0]  hi_in;

   logic               out_valid_ff;
   req_type            out_req_ff;
   flags_type          out_flags_ff;
   logic [SLOT_W-1:0]  out_lo_ff;
   logic [SLOT_W-1:0]  out_hi_ff;

   assign span_sum = {1'b0, in_lo} + {1'b0, in_hi};
   assign mid      = SLOT_W'(span_sum >> 1);
   assign mid_next = mid + SLOT_W'(1);
   assign wr_addr  = SLOT_W'(in_req.wr_slot);
   assign wr_fire  = advance && in_valid && in_req.wr_en;

   ibl_ram #(
      .WIDTH (START_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram_mid (
      .clock   (clock),
      .wr_en   (wr_fire),
      .wr_addr (wr_addr),
      .wr_data (in_req.wr_start),
      .rd_en   (advance),
      .rd_addr (mid),
      .rd_data (mid_start)
   );

   ibl_ram #(
      .WIDTH (START_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram_next (
      .clock   (clock),
      .wr_en   (wr_fire),
      .wr_addr (wr_addr),
      .wr_data (in_req.wr_start),
      .rd_en   (advance),
      .rd_addr (mid_next),
      .rd_data (next_start)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_req_ff   <= in_req;
         s1_flags_ff <= in_flags;
         s1_lo_ff    <= in_lo;
         s1_hi_ff    <= in_hi;
         s1_mid_ff   <= mid;
      end
   end

   // narrow the bucket, or stop once lo == hi or start[mid] <= value < start[mid+1]
   always_comb begin
      flags_in = s1_flags_ff;
      lo_in    = s1_lo_ff;
      hi_in    = s1_hi_ff;
      if (s1_flags_ff.active) begin
         priority if (s1_lo_ff == s1_hi_ff) begin
            flags_in.active = 1'b0;
         end else if (mid_start <= s1_req_ff.value) begin
            lo_in = s1_mid_ff;
            if (next_start > s1_req_ff.value) begin
               flags_in.active = 1'b0;
            end
         end else begin
            hi_in = s1_mid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_req_ff   <= s1_req_ff;
         out_flags_ff <= flags_in;
         out_lo_ff    <= lo_in;
         out_hi_ff    <= hi_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_req   = out_req_ff;
   assign out_flags = out_flags_ff;
   assign out_lo    = out_lo_ff;
   assign out_hi    = out_hi_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ibl_fetch.sv =====
// Final stage: feature id read for the chosen slot and the response register.
`timescale 1ns / 1ps
`default_nettype none

module ibl_fetch import ibl_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  req_type                        in_req,
   input  flags_type                      in_flags,
   input  logic [$clog2(TABLE_DEPTH)-1:0] in_lo,
   output logic                           rsp_valid,
   output logic                           rsp_found,
   output logic [FEATURE_W-1:0]           rsp_feature,
   output logic [SLOT_FIELD_W-1:0]        rsp_slot
);

   localparam int unsigned SLOT_W = $clog2(TABLE_DEPTH);

   logic [SLOT_W-1:0]       wr_addr;
   logic                    wr_fire;
   logic [FEATURE_W-1:0]    slot_feature;

   logic                    s1_valid_ff;
   logic                    s1_found_ff;
   logic [SLOT_W-1:0]       s1_slot_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_found_ff;
   logic [FEATURE_W-1:0]    rsp_feature_ff;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff;

   assign wr_addr = SLOT_W'(in_req.wr_slot);
   assign wr_fire = advance && in_valid && in_req.wr_en;

   ibl_ram #(
      .WIDTH (FEATURE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram_feature (
      .clock   (clock),
      .wr_en   (wr_fire),
      .wr_addr (wr_addr),
      .wr_data (in_req.wr_feature),
      .rd_en   (advance),
      .rd_addr (in_lo),
      .rd_data (slot_feature)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= in_valid && in_req.lookup;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_found_ff    <= in_flags.found;
         s1_slot_ff     <= in_lo;
         rsp_found_ff   <= s1_found_ff;
         rsp_feature_ff <= s1_found_ff ? slot_feature : NULL_FEATURE;
         rsp_slot_ff    <= s1_found_ff ? SLOT_FIELD_W'(s1_slot_ff) : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_feature = rsp_feature_ff;
   assign rsp_slot    = rsp_slot_ff;

endmodule

`default_nettype wire

// ===== rtl/core/interval_bucket_lookup_unit.sv =====
// Requests pass the entry stage, the bisection steps and the fetch stage, in that order.
// Throughput: one request per cycle when not stalled; each step owns two table copies.
// Write requests update every copy as they pass, so requests see the table in order.
// A stalled response freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears the pipeline valid bits and entry_count; table contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module interval_bucket_lookup_unit import ibl_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entry_slot[9:0], entry_start[41:10], entry_feature[105:42], lookup_index[137:106]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // feature_id[63:0], bucket_slot[73:64]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // found[0]
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [COUNT_W-1:0]    csr_data
);

   localparam int unsigned SLOT_W = $clog2(TABLE_DEPTH);
   localparam int unsigned LEVELS = $clog2(TABLE_DEPTH) + 1;

   logic                    advance;
   logic [COUNT_W-1:0]      entry_count_ff;
   req_type                 in_req;

   logic                    stage_valid [LEVELS+1];
   req_type                 stage_req   [LEVELS+1];
   flags_type               stage_flags [LEVELS+1];
   logic [SLOT_W-1:0]       stage_lo    [LEVELS+1];
   logic [SLOT_W-1:0]       stage_hi    [LEVELS+1];

   logic                    rsp_found;
   logic [FEATURE_W-1:0]    rsp_feature;
   logic [SLOT_FIELD_W-1:0] rsp_slot;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_valid) begin
         entry_count_ff <= csr_data;
      end
   end

   always_comb begin
      in_req            = '0;
      in_req.lookup     = (req_tuser == CMD_LOOKUP);
      in_req.wr_slot    = req_tdata[9:0];
      in_req.wr_start   = req_tdata[41:10];
      in_req.wr_feature = req_tdata[105:42];
      in_req.value      = req_tdata[137:106];
      in_req.wr_en      = (req_tuser == CMD_WRITE) &&
                          (32'(req_tdata[9:0]) < 32'(TABLE_DEPTH));
   end

   ibl_entry #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_entry (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_tvalid),
      .in_req      (in_req),
      .entry_count (entry_count_ff),
      .out_valid   (stage_valid[0]),
      .out_req     (stage_req[0]),
      .out_flags   (stage_flags[0]),
      .out_lo      (stage_lo[0]),
      .out_hi      (stage_hi[0])
   );

   for (genvar k = 0; k < LEVELS; k++) begin : g_step
      ibl_step #(
         .TABLE_DEPTH (TABLE_DEPTH)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[k]),
         .in_req    (stage_req[k]),
         .in_flags  (stage_flags[k]),
         .in_lo     (stage_lo[k]),
         .in_hi     (stage_hi[k]),
         .out_valid (stage_valid[k+1]),
         .out_req   (stage_req[k+1]),
         .out_flags (stage_flags[k+1]),
         .out_lo    (stage_lo[k+1]),
         .out_hi    (stage_hi[k+1])
      );
   end

   ibl_fetch #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_fetch (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (stage_valid[LEVELS]),
      .in_req      (stage_req[LEVELS]),
      .in_flags    (stage_flags[LEVELS]),
      .in_lo       (stage_lo[LEVELS]),
      .rsp_valid   (rsp_tvalid),
      .rsp_found   (rsp_found),
      .rsp_feature (rsp_feature),
      .rsp_slot    (rsp_slot)
   );

   assign rsp_tdata = {(RSP_DATA_W - FEATURE_W - SLOT_FIELD_W)'(0), rsp_slot, rsp_feature};
   assign rsp_tuser = rsp_found;

endmodule

`default_nettype wire

// ===== rtl/core/ibl_checker.sv =====
// Port-level checks of the interval bucket lookup unit and their bind.
`timescale 1ns / 1ps
`default_nettype none

module ibl_checker import ibl_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while response stalled");

   a_miss_null: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[63:0] == NULL_FEATURE && rsp_tdata[73:64] == '0)
      else $error("miss response without null feature and slot zero");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind interval_bucket_lookup_unit ibl_checker u_ibl_checker (.*);

`default_nettype wire
